FILE: rtl/core/omrq_pkg.sv
// Shared constants and helpers for the overwriting message ring queue.
package omrq_pkg;

  localparam int SLOTS      = 8;
  localparam int SLOT_BYTES = 64;

  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH      = SLOTS * SLOT_BYTES;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths fixed by the interface.
  localparam int REQ_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int LEN_W      = 7;
  localparam int TAIL_OUT_W = 3;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERWR  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BYTE    = 3'd4;

  localparam logic [LEN_W-1:0] SLOT_BYTES_LEN = LEN_W'(SLOT_BYTES);

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [ADDR_W-1:0] byte_addr_t;

  // Ring successor of a slot index.
  function automatic slot_idx_t next_slot(input slot_idx_t i);
    next_slot = (i == slot_idx_t'(SLOTS - 1)) ? '0 : slot_idx_t'(i + 1'b1);
  endfunction

  // Address of a byte position inside a slot.
  function automatic byte_addr_t byte_addr(input slot_idx_t s, input logic [LEN_W-1:0] pos);
    byte_addr = byte_addr_t'(ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos));
  endfunction

endpackage

FILE: rtl/core/overwriting_message_ring_queue.sv
// Top level of the overwriting message ring queue: slot stores and sequencing.
//
// A ring of SLOTS message slots of up to SLOT_BYTES bytes each; one slot stays
// unused, so SLOTS-1 messages are held. A transaction is taken on a rising edge
// with start high and busy low. A write transaction carries a byte or none; the one
// marked last commits the message, and a commit into a full queue drops the
// oldest message. A message longer than a slot is dropped with a status.
// A peek replays the oldest message without removing it; a pop removes it.
// Every result appears for one cycle with out_strobe and must be taken then;
// the receiver cannot stall the block.
// Writes, pops, empty peeks and unused codes give one result in the cycle
// after the transaction, and busy stays low, so one transaction per cycle.
// A peek of a stored message reads the length memory and the byte memory,
// then streams one byte per cycle with busy high, giving one result per
// byte of the message, and a single result for an empty message.
// The rate of a peek is set by the single read port of the byte memory.
// Synchronous reset empties the queue and clears any partial write; the
// memories themselves are not cleared, since only committed slots are read.
module overwriting_message_ring_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [omrq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [omrq_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_has_byte,
  input  logic                            in_is_last,
  output logic                            out_strobe,
  output logic [omrq_pkg::STATUS_W-1:0]   out_status,
  output logic [omrq_pkg::BYTE_W-1:0]     out_data_out,
  output logic [omrq_pkg::LEN_W-1:0]      out_msg_length,
  output logic                            out_last_out,
  output logic                            out_queue_full,
  output logic                            out_queue_empty,
  output logic [omrq_pkg::TAIL_OUT_W-1:0] out_tail_index
);
  import omrq_pkg::*;

  localparam logic SQ_IDLE = 1'b0;
  localparam logic SQ_PEEK = 1'b1;

  // Slot stores: synchronous memories with registered reads.
  logic [BYTE_W-1:0] byte_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem  [SLOTS];

  logic              state_r, state_nxt;
  slot_idx_t         head_r, head_nxt;
  slot_idx_t         tail_r, tail_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;

  logic [BYTE_W-1:0] byte_rd_r;
  logic [LEN_W-1:0]  len_rd_r;

  logic              strobe_r, strobe_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]  mlen_r, mlen_nxt;
  logic              last_r, last_nxt;
  logic              full_r, full_nxt;
  logic              empty_r, empty_nxt;
  slot_idx_t         tail_out_r;

  // Memory port controls.
  logic              bwr_en;
  byte_addr_t        bwr_addr;
  logic              lwr_en;
  slot_idx_t         lwr_addr;
  logic [LEN_W-1:0]  lwr_data;
  logic              lrd_en;
  byte_addr_t        brd_addr;

  logic              accept;
  logic              q_empty;
  logic              q_full;
  slot_idx_t         target;
  slot_idx_t         peek_slot;
  logic              store_byte;
  logic              ovf_after;
  logic [LEN_W-1:0]  fill_after;
  logic [LEN_W-1:0]  peek_len;
  logic              peek_done;

  assign busy      = (state_r == SQ_PEEK);
  assign accept    = start && !busy;
  assign q_empty   = (head_r == tail_r);
  assign q_full    = (next_slot(tail_r) == head_r);
  assign target    = next_slot(tail_r);
  assign peek_slot = next_slot(head_r);

  // Byte write path of a write transaction.
  assign store_byte = in_has_byte && (fill_r < SLOT_BYTES_LEN);
  assign ovf_after  = ovf_r || (in_has_byte && !(fill_r < SLOT_BYTES_LEN));
  assign fill_after = fill_r + LEN_W'(store_byte);

  // A stored length never exceeds a slot, but the replay is bounded anyway.
  assign peek_len  = (len_rd_r > SLOT_BYTES_LEN) ? SLOT_BYTES_LEN : len_rd_r;
  assign peek_done = (peek_len == '0) || (idx_r + 1'b1 == peek_len);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    status_nxt = ST_OK;
    data_nxt   = '0;
    mlen_nxt   = '0;
    last_nxt   = 1'b1;
    bwr_en     = 1'b0;
    bwr_addr   = byte_addr(target, fill_r);
    lwr_en     = 1'b0;
    lwr_addr   = target;
    lwr_data   = fill_after;
    lrd_en     = 1'b0;
    brd_addr   = byte_addr(peek_slot, idx_r + 1'b1);

    if (state_r == SQ_PEEK) begin
      // Stream one stored byte per cycle while the next one is being read.
      strobe_nxt = 1'b1;
      if (peek_len != '0) begin
        data_nxt = byte_rd_r;
        mlen_nxt = peek_len;
      end
      last_nxt = peek_done;
      idx_nxt  = idx_r + 1'b1;
      if (peek_done) begin
        state_nxt = SQ_IDLE;
      end
    end else if (accept) begin
      strobe_nxt = 1'b1;
      case (in_req_type)
        REQ_WRITE: begin
          bwr_en = store_byte;
          if (!in_is_last) begin
            fill_nxt   = fill_after;
            ovf_nxt    = ovf_after;
            status_nxt = ST_BYTE;
          end else begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
            if (ovf_after) begin
              status_nxt = ST_DROPPED;
            end else begin
              lwr_en   = 1'b1;
              tail_nxt = target;
              if (q_full) begin
                head_nxt   = next_slot(head_r);
                status_nxt = ST_OVERWR;
              end else begin
                status_nxt = ST_OK;
              end
            end
          end
        end
        REQ_PEEK: begin
          if (q_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            // No result yet: the first one follows once the reads return.
            strobe_nxt = 1'b0;
            lrd_en     = 1'b1;
            brd_addr   = byte_addr(peek_slot, '0);
            idx_nxt    = '0;
            state_nxt  = SQ_PEEK;
          end
        end
        REQ_POP: begin
          if (q_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = next_slot(head_r);
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end

    full_nxt  = (next_slot(tail_nxt) == head_nxt);
    empty_nxt = (head_nxt == tail_nxt);
  end

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (bwr_en) begin
      byte_mem[bwr_addr] <= in_data_byte;
    end
    byte_rd_r <= byte_mem[brd_addr];
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      len_mem[lwr_addr] <= lwr_data;
    end
    if (lrd_en) begin
      len_rd_r <= len_mem[peek_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SQ_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Result payload registers; meaningful only while the strobe is high.
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    mlen_r     <= mlen_nxt;
    last_r     <= last_nxt;
    full_r     <= full_nxt;
    empty_r    <= empty_nxt;
    tail_out_r <= tail_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_msg_length  = mlen_r;
  assign out_last_out    = last_r;
  assign out_queue_full  = full_r;
  assign out_queue_empty = empty_r;
  assign out_tail_index  = TAIL_OUT_W'(tail_out_r);

`ifndef ASSERT_OFF
  // Every transaction other than a peek of a stored message answers next cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_req_type == REQ_PEEK && !q_empty)) |=> strobe_r)
    else $error("single-result transaction gave no result");

  // The partial write never holds more bytes than a slot.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= SLOT_BYTES_LEN)
    else $error("write fill exceeds slot size");

  // A replay never runs past the stored length.
  a_peek_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_PEEK && peek_len != '0) |-> (idx_r < peek_len))
    else $error("peek index beyond message length");

  // The queue does not change while a peek is streaming.
  a_peek_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_PEEK) |=> ($stable(head_r) && $stable(tail_r)))
    else $error("head or tail moved during a peek");
`endif

endmodule
